FILE: sv/vector_bin_fit_and_place_core_defines.svh
// Assertion macros shared by the checker files.
`ifndef VECTOR_BIN_FIT_AND_PLACE_CORE_DEFINES_SVH
`define VECTOR_BIN_FIT_AND_PLACE_CORE_DEFINES_SVH

// Concurrent property, sampled on clk_i, off while rst_ni is low.
`define VBFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen, sampled on clk_i, off while rst_ni is low.
`define VBFP_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

FILE: sv/vbfp_pkg.sv
package vbfp_pkg;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned BIN_W      = 4;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned SUM_OUT_W  = 18;
  localparam int unsigned MAX_DIMS   = 4;

  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;

  localparam int unsigned BIN_LSB    = 0;
  localparam int unsigned ID_LSB     = BIN_LSB + BIN_W;
  localparam int unsigned UNIT_LSB   = ID_LSB + ID_W;
  localparam int unsigned TOTAL_LSB  = UNIT_LSB + MAX_DIMS * FIELD_W;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TRY   = 2'd1,
    KIND_FORCE = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef struct packed {
    logic fits;
    logic placed;
  } merge_res_t;

endpackage

FILE: sv/vbfp_lane.sv
module vbfp_lane import vbfp_pkg::*; #(
  parameter int unsigned AW = 16
) (
  input  logic [AW-1:0] unit_need_i,
  input  logic [AW-1:0] total_need_i,
  input  logic [AW-1:0] unit_cap_i,
  input  logic [AW-1:0] total_cap_i,
  input  logic [AW-1:0] load_i,
  output logic          fit_o,
  output logic [AW-1:0] new_load_o
);

  logic [AW:0] sum;

  assign sum        = {1'b0, load_i} + {1'b0, total_need_i};
  assign fit_o      = (unit_need_i <= unit_cap_i) && (sum <= {1'b0, total_cap_i});
  assign new_load_o = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];

endmodule

FILE: sv/vbfp_merge.sv
module vbfp_merge import vbfp_pkg::*; #(
  parameter int unsigned DIMS = 4,
  parameter int unsigned AW   = 16
) (
  input  kind_e                     kind_i,
  input  logic                      in_range_i,
  input  logic [DIMS-1:0]           lane_fit_i,
  input  logic [DIMS-1:0][AW-1:0]   old_load_i,
  input  logic [DIMS-1:0][AW-1:0]   new_load_i,
  output merge_res_t                res_o,
  output logic [DIMS-1:0][AW-1:0]   final_load_o,
  output logic [AW+1:0]             sum_o
);

  logic fits;
  logic placed;

  assign fits   = in_range_i && (kind_i != KIND_LOAD) && (&lane_fit_i);
  assign placed = in_range_i && ((kind_i == KIND_FORCE) || ((kind_i == KIND_TRY) && fits));

  assign res_o.fits   = fits;
  assign res_o.placed = placed;

  always_comb begin
    sum_o = '0;
    for (int d = 0; d < DIMS; d++) begin
      if (kind_i == KIND_LOAD) begin
        final_load_o[d] = '0;
      end else if (placed) begin
        final_load_o[d] = new_load_i[d];
      end else begin
        final_load_o[d] = old_load_i[d];
      end
      sum_o = sum_o + (AW+2)'(final_load_o[d]);
    end
    if (!in_range_i) begin
      sum_o = '0;
    end
  end

endmodule

FILE: sv/vector_bin_fit_and_place_core.sv
// Vector bin fit-and-place engine. Each word on the slave side addresses one bin: kind 0 loads
// the bin's unit and total capacities and clears its loads, kind 1 places the item only if it
// fits in every dimension, kind 2 places it regardless, kind 3 only reports the fit. Every word
// yields one result word with the echoed ids, fit and placed flags and the bin's load sum
// (18 bits). One word is in flight at a time; it passes through the input register, the bin
// memory read, the per-dimension lane check and the merge with write-back before its result is
// registered. A stalled master side holds the merge step until the result is taken. Bins start
// cleared through per-bin valid flags, so no clearing pass follows reset.
module vector_bin_fit_and_place_core import vbfp_pkg::*; #(
  parameter int unsigned DIMS        = 4,
  parameter int unsigned BINS        = 16,
  parameter int unsigned AMOUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // bin, item_id, unit_d0..unit_d3, total_d0..total_d3, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // item_echo, bin_echo, fits, placed, bin_load_sum, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW    = AMOUNT_BITS;
  localparam int unsigned SUM_W = AW + 2;
  localparam int unsigned ROW_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned EXT_W = BIN_W + 8;

  typedef logic [DIMS-1:0][AW-1:0] amt_vec_t;

  typedef struct packed {
    amt_vec_t unit_cap;
    amt_vec_t total_cap;
    amt_vec_t load;
  } row_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  kind_e            kind_q;
  logic [BIN_W-1:0] bin_q;
  logic [ID_W-1:0]  id_q;
  amt_vec_t         unit_q, total_q;
  amt_vec_t         unit_in, total_in;

  row_t             mem_q [BINS];
  logic [BINS-1:0]  valid_q;
  row_t             rd_row_q;
  logic             rd_valid_q;
  row_t             rd_row;
  row_t             row_wr;

  logic [DIMS-1:0]  lane_fit;
  amt_vec_t         lane_new;
  logic [DIMS-1:0]  lane_fit_q;
  amt_vec_t         lane_new_q;

  merge_res_t       res;
  amt_vec_t         final_load;
  logic [SUM_W-1:0] sum;

  logic [EXT_W-1:0] bin_ext;
  logic [ROW_W-1:0] idx;
  logic             in_range;
  logic             in_fire;
  logic             out_free;
  logic             wr_en;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  for (genvar gd = 0; gd < DIMS; gd++) begin : g_unpack
    assign unit_in[gd]  = AW'(s_axis_tdata[UNIT_LSB + FIELD_W*gd +: FIELD_W]);
    assign total_in[gd] = AW'(s_axis_tdata[TOTAL_LSB + FIELD_W*gd +: FIELD_W]);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign bin_ext  = {8'd0, bin_q};
  assign in_range = bin_ext < EXT_W'(BINS);
  assign idx      = bin_ext[ROW_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_READ;
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_e'(s_axis_tuser);
      bin_q   <= s_axis_tdata[BIN_LSB +: BIN_W];
      id_q    <= s_axis_tdata[ID_LSB +: ID_W];
      unit_q  <= unit_in;
      total_q <= total_in;
    end
  end

  // bin memory: one read in ST_READ, one write-back in ST_DONE for an in-range bin
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx] <= row_wr;
    end
    if (state_q == ST_READ) begin
      rd_row_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[idx] <= 1'b1;
      end
      if (state_q == ST_READ) begin
        rd_valid_q <= in_range && valid_q[idx];
      end
    end
  end

  assign rd_row = rd_valid_q ? rd_row_q : '0;

  for (genvar gl = 0; gl < DIMS; gl++) begin : g_lane
    vbfp_lane #(
      .AW (AW)
    ) u_lane (
      .unit_need_i  (unit_q[gl]),
      .total_need_i (total_q[gl]),
      .unit_cap_i   (rd_row.unit_cap[gl]),
      .total_cap_i  (rd_row.total_cap[gl]),
      .load_i       (rd_row.load[gl]),
      .fit_o        (lane_fit[gl]),
      .new_load_o   (lane_new[gl])
    );
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      lane_fit_q <= lane_fit;
      lane_new_q <= lane_new;
    end
  end

  vbfp_merge #(
    .DIMS (DIMS),
    .AW   (AW)
  ) u_merge (
    .kind_i       (kind_q),
    .in_range_i   (in_range),
    .lane_fit_i   (lane_fit_q),
    .old_load_i   (rd_row.load),
    .new_load_i   (lane_new_q),
    .res_o        (res),
    .final_load_o (final_load),
    .sum_o        (sum)
  );

  assign wr_en = (state_q == ST_DONE) && out_free && in_range;

  always_comb begin
    if (kind_q == KIND_LOAD) begin
      row_wr.unit_cap  = unit_q;
      row_wr.total_cap = total_q;
      row_wr.load      = '0;
    end else begin
      row_wr.unit_cap  = rd_row.unit_cap;
      row_wr.total_cap = rd_row.total_cap;
      row_wr.load      = final_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      m_data_q <= {6'd0, SUM_OUT_W'(sum), res.placed, res.fits, bin_q, id_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: sv/vbfp_checker.sv
`include "vector_bin_fit_and_place_core_defines.svh"

module vbfp_checker import vbfp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  logic m_stall;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  `VBFP_ASSERT(a_out_hold, m_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "word not held")
  `VBFP_ASSERT(a_busy_after_accept, s_acc |=> !s_axis_tready, "ready right after a word")
  `VBFP_NEVER(a_busy_two_after, s_axis_tready && $past(s_acc, 2), "ready two cycles after a word")
  `VBFP_ASSERT(a_latency, $rose(m_axis_tvalid) |-> $past(s_acc, 4), "late or early result")

endmodule

bind vector_bin_fit_and_place_core vbfp_checker u_vbfp_checker (.*);
